// File: sv/assert_macros.svh
// Assertion macros used by the top level of the byte and word ALU.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in same-cycle check");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in next-cycle check");

`endif

// File: sv/bwalu_pkg.sv
// Package with command codes, flag masks and pipeline stage types of the ALU.
package bwalu_pkg;

  // Operation codes carried on the command field.
  typedef enum logic [4:0] {
    CMD_ADC = 5'd0,
    CMD_AND = 5'd1,
    CMD_ASL = 5'd2,
    CMD_CMP = 5'd3,
    CMD_DEC = 5'd4,
    CMD_EOR = 5'd5,
    CMD_INC = 5'd6,
    CMD_LD  = 5'd7,
    CMD_LSR = 5'd8,
    CMD_OR  = 5'd9,
    CMD_ROL = 5'd10,
    CMD_ROR = 5'd11,
    CMD_SBC = 5'd12,
    CMD_ADW = 5'd13,
    CMD_CPW = 5'd14,
    CMD_LDW = 5'd15,
    CMD_SBW = 5'd16
  } cmd_t;

  // Flag mask bits and common combinations.
  localparam logic [4:0] MASK_C    = 5'h01;
  localparam logic [4:0] MASK_Z    = 5'h02;
  localparam logic [4:0] MASK_H    = 5'h04;
  localparam logic [4:0] MASK_V    = 5'h08;
  localparam logic [4:0] MASK_N    = 5'h10;
  localparam logic [4:0] MASK_NONE = 5'h00;
  localparam logic [4:0] MASK_ZN   = MASK_Z | MASK_N;
  localparam logic [4:0] MASK_CZN  = MASK_C | MASK_Z | MASK_N;
  localparam logic [4:0] MASK_ALL  = MASK_C | MASK_Z | MASK_H | MASK_V | MASK_N;

  // First stage: decoded command, low byte sum and the simple byte results.
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  a_hi;
    logic [7:0]  bx_hi;
    logic [8:0]  lo;
    logic        h_lo;
    logic        v_lo;
    logic [15:0] pass_val;
    logic        c_shift;
  } s1_t;

  // Second stage: adds the high byte sum.
  typedef struct packed {
    cmd_t        cmd;
    logic [8:0]  lo;
    logic        h_lo;
    logic        v_lo;
    logic [8:0]  hi;
    logic        h_hi;
    logic        v_hi;
    logic [15:0] pass_val;
    logic        c_shift;
  } s2_t;

  // Final result with flags.
  typedef struct packed {
    logic [15:0] result;
    logic        c;
    logic        z;
    logic        h;
    logic        v;
    logic        n;
    logic [4:0]  mask;
  } res_t;

endpackage

// File: sv/bwalu_front.sv
// Front stage logic: operand selection, low byte adder and byte logic operations.
module bwalu_front (
  input  logic [4:0]       command,
  input  logic [15:0]      operand_a,
  input  logic [15:0]      operand_b,
  input  logic             carry_in,
  output bwalu_pkg::s1_t   front
);

  bwalu_pkg::cmd_t cmd;
  logic [15:0]     bx;
  logic            cin;
  logic [8:0]      lo;
  logic [7:0]      a8;
  logic [15:0]     pass_val;
  logic            c_shift;

  assign cmd = bwalu_pkg::cmd_t'(command);
  assign a8  = operand_a[7:0];

  // Subtracts and compares add the complement of operand b.
  always_comb begin
    bx  = operand_b;
    cin = 1'b0;
    case (cmd)
      bwalu_pkg::CMD_ADC: begin
        cin = carry_in;
      end
      bwalu_pkg::CMD_SBC: begin
        bx  = ~operand_b;
        cin = carry_in;
      end
      bwalu_pkg::CMD_SBW, bwalu_pkg::CMD_CMP, bwalu_pkg::CMD_CPW: begin
        bx  = ~operand_b;
        cin = 1'b1;
      end
      default: begin
        bx  = operand_b;
        cin = 1'b0;
      end
    endcase
  end

  // Low byte adder shared by all add, subtract and compare operations.
  assign lo = {1'b0, a8} + {1'b0, bx[7:0]} + {8'd0, cin};

  // Results taken straight from the operands or from byte logic, plus shift carry.
  always_comb begin
    pass_val = 16'd0;
    c_shift  = 1'b0;
    case (cmd)
      bwalu_pkg::CMD_AND: pass_val = {8'd0, a8 & operand_b[7:0]};
      bwalu_pkg::CMD_EOR: pass_val = {8'd0, a8 ^ operand_b[7:0]};
      bwalu_pkg::CMD_OR:  pass_val = {8'd0, a8 | operand_b[7:0]};
      bwalu_pkg::CMD_DEC: pass_val = {8'd0, a8 - 8'd1};
      bwalu_pkg::CMD_INC: pass_val = {8'd0, a8 + 8'd1};
      bwalu_pkg::CMD_LD:  pass_val = {8'd0, operand_b[7:0]};
      bwalu_pkg::CMD_CMP: pass_val = {8'd0, a8};
      bwalu_pkg::CMD_CPW: pass_val = operand_a;
      bwalu_pkg::CMD_LDW: pass_val = operand_b;
      bwalu_pkg::CMD_ASL: begin
        pass_val = {8'd0, a8[6:0], 1'b0};
        c_shift  = a8[7];
      end
      bwalu_pkg::CMD_LSR: begin
        pass_val = {8'd0, 1'b0, a8[7:1]};
        c_shift  = a8[0];
      end
      bwalu_pkg::CMD_ROL: begin
        pass_val = {8'd0, a8[6:0], carry_in};
        c_shift  = a8[7];
      end
      bwalu_pkg::CMD_ROR: begin
        pass_val = {8'd0, carry_in, a8[7:1]};
        c_shift  = a8[0];
      end
      default: begin
        pass_val = 16'd0;
        c_shift  = 1'b0;
      end
    endcase
  end

  // Pack the stage outputs, with half-carry and overflow of the low byte.
  always_comb begin
    front.cmd      = cmd;
    front.a_hi     = operand_a[15:8];
    front.bx_hi    = bx[15:8];
    front.lo       = lo;
    front.h_lo     = a8[4] ^ bx[4] ^ lo[4];
    front.v_lo     = ~(a8[7] ^ bx[7]) & (a8[7] ^ lo[7]);
    front.pass_val = pass_val;
    front.c_shift  = c_shift;
  end

endmodule

// File: sv/byte_and_word_alu_with_flags.sv
// Top level of the byte and word ALU: three-stage pipeline with flag generation.
//
// Usage: a request enters on command, operand_a, operand_b and carry_in with
// cmd_valid; it is taken at a rising edge where cmd_valid is high and
// cmd_stall is low. The result leaves on result, the five flag outputs and
// flag_mask with res_valid, and is taken where res_valid is high and
// res_stall is low. Flags whose mask bit is clear read as zero.
// A request taken at one edge passes through the three register stages in
// order (low byte add, high byte add, flag select) before its result shows.
// One request enters every cycle while cmd_stall is low; each stage moves
// on whenever the stage after it has room.
// When the receiver stalls, the result holds and the stages fill up behind
// it; cmd_stall rises only once every stage holds a request, and nothing
// is lost or repeated. Reset empties all stages.
`include "assert_macros.svh"

module byte_and_word_alu_with_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [4:0]  command,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic        carry_in,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [15:0] result,
  output logic        carry_out,
  output logic        zero_out,
  output logic        half_out,
  output logic        overflow_out,
  output logic        negative_out,
  output logic [4:0]  flag_mask
);

  bwalu_pkg::s1_t  front;
  bwalu_pkg::s1_t  st1;
  bwalu_pkg::s2_t  st2_next;
  bwalu_pkg::s2_t  st2;
  bwalu_pkg::res_t st3_next;
  bwalu_pkg::res_t st3;
  logic            v1;
  logic            v2;
  logic            v3;
  logic            ready1;
  logic            ready2;
  logic            ready3;
  logic [8:0]      hi;
  logic [4:0]      flag_bits;

  // Operand selection, low byte adder and byte logic results.
  bwalu_front u_front (
    .command   (command),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .carry_in  (carry_in),
    .front     (front)
  );

  // A stage can load when it is empty or its content moves on.
  assign ready3    = ~v3 | ~res_stall;
  assign ready2    = ~v2 | ready3;
  assign ready1    = ~v1 | ready2;
  assign cmd_stall = ~ready1;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= cmd_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (ready1 && cmd_valid) st1 <= front;
  end

  // High byte adder chained on the low byte carry.
  assign hi = {1'b0, st1.a_hi} + {1'b0, st1.bx_hi} + {8'd0, st1.lo[8]};

  always_comb begin
    st2_next.cmd      = st1.cmd;
    st2_next.lo       = st1.lo;
    st2_next.h_lo     = st1.h_lo;
    st2_next.v_lo     = st1.v_lo;
    st2_next.hi       = hi;
    st2_next.h_hi     = st1.a_hi[4] ^ st1.bx_hi[4] ^ hi[4];
    st2_next.v_hi     = ~(st1.a_hi[7] ^ st1.bx_hi[7]) & (st1.a_hi[7] ^ hi[7]);
    st2_next.pass_val = st1.pass_val;
    st2_next.c_shift  = st1.c_shift;
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) st2 <= st2_next;
  end

  // Result and flag selection per command.
  always_comb begin
    st3_next = '0;
    case (st2.cmd)
      bwalu_pkg::CMD_ADC, bwalu_pkg::CMD_SBC: begin
        st3_next.result = {8'd0, st2.lo[7:0]};
        st3_next.c      = st2.lo[8];
        st3_next.z      = (st2.lo[7:0] == 8'd0);
        st3_next.h      = st2.h_lo;
        st3_next.v      = st2.v_lo;
        st3_next.n      = st2.lo[7];
        st3_next.mask   = bwalu_pkg::MASK_ALL;
      end
      bwalu_pkg::CMD_AND, bwalu_pkg::CMD_EOR, bwalu_pkg::CMD_OR,
      bwalu_pkg::CMD_DEC, bwalu_pkg::CMD_INC, bwalu_pkg::CMD_LD: begin
        st3_next.result = st2.pass_val;
        st3_next.z      = (st2.pass_val[7:0] == 8'd0);
        st3_next.n      = st2.pass_val[7];
        st3_next.mask   = bwalu_pkg::MASK_ZN;
      end
      bwalu_pkg::CMD_ASL, bwalu_pkg::CMD_LSR,
      bwalu_pkg::CMD_ROL, bwalu_pkg::CMD_ROR: begin
        st3_next.result = st2.pass_val;
        st3_next.c      = st2.c_shift;
        st3_next.z      = (st2.pass_val[7:0] == 8'd0);
        st3_next.n      = st2.pass_val[7];
        st3_next.mask   = bwalu_pkg::MASK_CZN;
      end
      bwalu_pkg::CMD_CMP: begin
        st3_next.result = st2.pass_val;
        st3_next.c      = st2.lo[8];
        st3_next.z      = (st2.lo[7:0] == 8'd0);
        st3_next.n      = st2.lo[7];
        st3_next.mask   = bwalu_pkg::MASK_CZN;
      end
      bwalu_pkg::CMD_ADW, bwalu_pkg::CMD_SBW: begin
        st3_next.result = {st2.hi[7:0], st2.lo[7:0]};
        st3_next.c      = st2.hi[8];
        st3_next.z      = ({st2.hi[7:0], st2.lo[7:0]} == 16'd0);
        st3_next.h      = st2.h_hi;
        st3_next.v      = st2.v_hi;
        st3_next.n      = st2.hi[7];
        st3_next.mask   = bwalu_pkg::MASK_ALL;
      end
      bwalu_pkg::CMD_CPW: begin
        st3_next.result = st2.pass_val;
        st3_next.c      = st2.hi[8];
        st3_next.z      = ({st2.hi[7:0], st2.lo[7:0]} == 16'd0);
        st3_next.n      = st2.hi[7];
        st3_next.mask   = bwalu_pkg::MASK_CZN;
      end
      bwalu_pkg::CMD_LDW: begin
        st3_next.result = st2.pass_val;
        st3_next.z      = (st2.pass_val == 16'd0);
        st3_next.n      = st2.pass_val[15];
        st3_next.mask   = bwalu_pkg::MASK_ZN;
      end
      default: begin
        st3_next      = '0;
        st3_next.mask = bwalu_pkg::MASK_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) st3 <= st3_next;
  end

  // Output register drives the result channel.
  assign res_valid    = v3;
  assign result       = st3.result;
  assign carry_out    = st3.c;
  assign zero_out     = st3.z;
  assign half_out     = st3.h;
  assign overflow_out = st3.v;
  assign negative_out = st3.n;
  assign flag_mask    = st3.mask;

  // Flag outputs in mask bit order.
  assign flag_bits = {negative_out, overflow_out, half_out, zero_out, carry_out};

  // A flag outside the mask is never set.
  `ASSERT_SAME(a_flags_in_mask, clk, rst, res_valid, ((~flag_mask) & flag_bits) == 5'd0)
  // Half-carry is only reported by full-flag arithmetic.
  `ASSERT_SAME(a_half_full_mask, clk, rst, res_valid && flag_mask[2], flag_mask == bwalu_pkg::MASK_ALL)
  // An accepted request lands in the first stage.
  `ASSERT_NEXT(a_accept_loads, clk, rst, cmd_valid && !cmd_stall, v1)
  // A blocked middle stage keeps its request.
  `ASSERT_NEXT(a_stage2_holds, clk, rst, v2 && !ready3, v2 && $stable(st2))

endmodule

// File: tb/tb.sv
// Testbench for the byte and word ALU: predicts every result and flag and checks it.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes past the last operation that the block must treat as no-ops.
  localparam logic [4:0] CMD_FIRST_UNUSED = 5'd17;
  localparam logic [4:0] CMD_LAST_UNUSED  = 5'd31;

  localparam int unsigned PIPE_LATENCY = 3;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned HOLD_CYCLES  = 50;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned IDLE_PERCENT = 6;
  localparam int unsigned PRINT_LIMIT  = 40;

  // One byte step of the adder with its flags.
  typedef struct packed {
    logic [7:0] sum;
    logic       c;
    logic       h;
    logic       v;
    logic       n;
  } byte_sum_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  logic [4:0]  command = 5'd0;
  logic [15:0] operand_a = 16'h0000;
  logic [15:0] operand_b = 16'h0000;
  logic        carry_in = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [15:0] result;
  logic        carry_out;
  logic        zero_out;
  logic        half_out;
  logic        overflow_out;
  logic        negative_out;
  logic [4:0]  flag_mask;

  bwalu_pkg::res_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  byte_and_word_alu_with_flags DUT (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .carry_in     (carry_in),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .result       (result),
    .carry_out    (carry_out),
    .zero_out     (zero_out),
    .half_out     (half_out),
    .overflow_out (overflow_out),
    .negative_out (negative_out),
    .flag_mask    (flag_mask)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Adds two bytes and a carry, producing carry, half-carry, overflow and sign.
  function automatic byte_sum_t byte_sum(logic [7:0] x, logic [7:0] y, logic cin);
    byte_sum_t bs;
    logic [8:0] s;
    s = {1'b0, x} + {1'b0, y} + {8'h00, cin};
    bs.sum = s[7:0];
    bs.c = s[8];
    bs.h = x[4] ^ y[4] ^ s[4];
    bs.v = ~(x[7] ^ y[7]) & (x[7] ^ s[7]);
    bs.n = s[7];
    return bs;
  endfunction

  // Computes the expected result and flags of one request.
  function automatic bwalu_pkg::res_t predict_alu(logic [4:0] cmd, logic [15:0] a,
                                                  logic [15:0] b, logic ci);
    bwalu_pkg::res_t r;
    byte_sum_t lo;
    byte_sum_t hi;
    logic [15:0] bb;
    logic [15:0] diff;
    bit byte_zn;
    r = '0;
    byte_zn = 1'b0;
    case (cmd)
      bwalu_pkg::CMD_ADC, bwalu_pkg::CMD_SBC: begin
        lo = byte_sum(a[7:0], (cmd == bwalu_pkg::CMD_SBC) ? ~b[7:0] : b[7:0], ci);
        r.result = {8'h00, lo.sum};
        r.c = lo.c;
        r.h = lo.h;
        r.v = lo.v;
        r.n = lo.n;
        r.z = (lo.sum == 8'h00);
        r.mask = bwalu_pkg::MASK_ALL;
      end
      bwalu_pkg::CMD_AND: begin r.result = {8'h00, a[7:0] & b[7:0]}; byte_zn = 1'b1; end
      bwalu_pkg::CMD_EOR: begin r.result = {8'h00, a[7:0] ^ b[7:0]}; byte_zn = 1'b1; end
      bwalu_pkg::CMD_OR:  begin r.result = {8'h00, a[7:0] | b[7:0]}; byte_zn = 1'b1; end
      bwalu_pkg::CMD_DEC: begin r.result = {8'h00, a[7:0] - 8'h01}; byte_zn = 1'b1; end
      bwalu_pkg::CMD_INC: begin r.result = {8'h00, a[7:0] + 8'h01}; byte_zn = 1'b1; end
      bwalu_pkg::CMD_LD:  begin r.result = {8'h00, b[7:0]}; byte_zn = 1'b1; end
      bwalu_pkg::CMD_ASL: begin
        r.result = {8'h00, a[6:0], 1'b0};
        r.c = a[7];
        byte_zn = 1'b1;
      end
      bwalu_pkg::CMD_LSR: begin
        r.result = {8'h00, 1'b0, a[7:1]};
        r.c = a[0];
        byte_zn = 1'b1;
      end
      bwalu_pkg::CMD_ROL: begin
        r.result = {8'h00, a[6:0], ci};
        r.c = a[7];
        byte_zn = 1'b1;
      end
      bwalu_pkg::CMD_ROR: begin
        r.result = {8'h00, ci, a[7:1]};
        r.c = a[0];
        byte_zn = 1'b1;
      end
      bwalu_pkg::CMD_CMP: begin
        diff = {8'h00, a[7:0] - b[7:0]};
        r.result = {8'h00, a[7:0]};
        r.c = (a[7:0] >= b[7:0]);
        r.z = (diff[7:0] == 8'h00);
        r.n = diff[7];
        r.mask = bwalu_pkg::MASK_CZN;
      end
      bwalu_pkg::CMD_ADW, bwalu_pkg::CMD_SBW: begin
        // Word add chains two byte steps; subtract adds the complement with carry set.
        bb = (cmd == bwalu_pkg::CMD_SBW) ? ~b : b;
        lo = byte_sum(a[7:0], bb[7:0], cmd == bwalu_pkg::CMD_SBW);
        hi = byte_sum(a[15:8], bb[15:8], lo.c);
        r.result = {hi.sum, lo.sum};
        r.c = hi.c;
        r.h = hi.h;
        r.v = hi.v;
        r.n = hi.n;
        r.z = ({hi.sum, lo.sum} == 16'h0000);
        r.mask = bwalu_pkg::MASK_ALL;
      end
      bwalu_pkg::CMD_CPW: begin
        diff = a - b;
        r.result = a;
        r.c = (a >= b);
        r.z = (diff == 16'h0000);
        r.n = diff[15];
        r.mask = bwalu_pkg::MASK_CZN;
      end
      bwalu_pkg::CMD_LDW: begin
        r.result = b;
        r.z = (b == 16'h0000);
        r.n = b[15];
        r.mask = bwalu_pkg::MASK_ZN;
      end
      default: r = '0;
    endcase
    // Logic, load and shift operations set zero and sign from the low byte.
    if (byte_zn) begin
      r.z = (r.result[7:0] == 8'h00);
      r.n = r.result[7];
      r.mask = r.mask | bwalu_pkg::MASK_ZN;
      if (cmd inside {bwalu_pkg::CMD_ASL, bwalu_pkg::CMD_LSR,
                      bwalu_pkg::CMD_ROL, bwalu_pkg::CMD_ROR})
        r.mask = bwalu_pkg::MASK_CZN;
    end
    // Flags that the operation leaves alone read as zero.
    if ((r.mask & bwalu_pkg::MASK_C) == bwalu_pkg::MASK_NONE) r.c = 1'b0;
    if ((r.mask & bwalu_pkg::MASK_Z) == bwalu_pkg::MASK_NONE) r.z = 1'b0;
    if ((r.mask & bwalu_pkg::MASK_H) == bwalu_pkg::MASK_NONE) r.h = 1'b0;
    if ((r.mask & bwalu_pkg::MASK_V) == bwalu_pkg::MASK_NONE) r.v = 1'b0;
    if ((r.mask & bwalu_pkg::MASK_N) == bwalu_pkg::MASK_NONE) r.n = 1'b0;
    return r;
  endfunction

  // Prints one mismatch line, up to a limit, and counts it.
  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("[%0t] result %0d: %s is %h, expected %h", $realtime, result_count, what,
               got, want);
  endtask

  // Sends one request, with random idle cycles before it, and records its expectation.
  task automatic send_request(logic [4:0] cmd, logic [15:0] a, logic [15:0] b, logic ci);
    while (!quiet && ($urandom_range(99) < IDLE_PERCENT)) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command   <= cmd;
    operand_a <= a;
    operand_b <= b;
    carry_in  <= ci;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    pending_results.push_back(predict_alu(cmd, a, b, ci));
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic wait_for_results();
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Operand values that favor the carry, sign and zero boundaries.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return {8'($urandom), 8'hFF};
      5: return {8'($urandom), 8'h80};
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly real operations, with some unused codes mixed in.
  function automatic logic [4:0] pick_command();
    if ($urandom_range(99) < 7)
      return 5'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED));
    return 5'($urandom_range(bwalu_pkg::CMD_SBW, bwalu_pkg::CMD_ADC));
  endfunction

  task automatic send_random_requests(int unsigned count);
    logic [15:0] a;
    for (int unsigned i = 0; i < count; i++) begin
      a = pick_operand();
      send_request(pick_command(), a, ($urandom_range(9) == 0) ? a : pick_operand(),
                   1'($urandom));
    end
  endtask

  // Boundary cases of every operation, including the unused codes.
  task automatic test_directed();
    send_request(bwalu_pkg::CMD_ADC, 16'h00FF, 16'h0001, 1'b1);
    send_request(bwalu_pkg::CMD_ADC, 16'h007F, 16'h0001, 1'b0);
    send_request(bwalu_pkg::CMD_SBC, 16'h0000, 16'h0001, 1'b1);
    send_request(bwalu_pkg::CMD_SBC, 16'hFF80, 16'hFF01, 1'b1);
    send_request(bwalu_pkg::CMD_AND, 16'hFFFF, 16'h0000, 1'b1);
    send_request(bwalu_pkg::CMD_OR,  16'h00F0, 16'h000F, 1'b0);
    send_request(bwalu_pkg::CMD_EOR, 16'hFFFF, 16'hFFFF, 1'b0);
    send_request(bwalu_pkg::CMD_DEC, 16'h0000, 16'hFFFF, 1'b1);
    send_request(bwalu_pkg::CMD_INC, 16'hFFFF, 16'h0000, 1'b0);
    send_request(bwalu_pkg::CMD_LD,  16'h0000, 16'hFF80, 1'b0);
    send_request(bwalu_pkg::CMD_ASL, 16'h0080, 16'h0000, 1'b1);
    send_request(bwalu_pkg::CMD_LSR, 16'h0001, 16'h0000, 1'b1);
    send_request(bwalu_pkg::CMD_ROL, 16'h0080, 16'h0000, 1'b1);
    send_request(bwalu_pkg::CMD_ROR, 16'h0001, 16'h0000, 1'b1);
    send_request(bwalu_pkg::CMD_CMP, 16'h1242, 16'h3442, 1'b0);
    send_request(bwalu_pkg::CMD_CMP, 16'h0010, 16'h0020, 1'b1);
    send_request(bwalu_pkg::CMD_ADW, 16'hFFFF, 16'h0001, 1'b0);
    send_request(bwalu_pkg::CMD_ADW, 16'h7FFF, 16'h0001, 1'b1);
    send_request(bwalu_pkg::CMD_SBW, 16'h0000, 16'h0001, 1'b0);
    send_request(bwalu_pkg::CMD_SBW, 16'h1234, 16'h1234, 1'b0);
    send_request(bwalu_pkg::CMD_CPW, 16'h0000, 16'hFFFF, 1'b1);
    send_request(bwalu_pkg::CMD_CPW, 16'hFFFF, 16'hFFFF, 1'b0);
    send_request(bwalu_pkg::CMD_LDW, 16'hFFFF, 16'h8000, 1'b1);
    send_request(bwalu_pkg::CMD_LDW, 16'hFFFF, 16'h0000, 1'b1);
    send_request(CMD_FIRST_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(CMD_LAST_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
  endtask

  task automatic test_random_with_idling();
    send_random_requests(900);
  endtask

  // Back to back requests and results with no idle cycle on either side.
  task automatic test_full_rate();
    quiet = 1'b1;
    send_random_requests(200);
    quiet = 1'b0;
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall requests.
  task automatic test_receiver_hold();
    quiet = 1'b1;
    hold_requests++;
    send_random_requests(60);
    quiet = 1'b0;
  endtask

  // The sender pauses until every result is back, then resumes.
  task automatic test_sender_pause();
    wait_for_results();
    send_random_requests(300);
  endtask

  // Receiver side: random stalls, and long holds counted here.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else begin
      res_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    bwalu_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", result, 16'h0000);
      end else begin
        want = pending_results.pop_front();
        if (result !== want.result) report_mismatch("result", result, want.result);
        if (carry_out !== want.c)
          report_mismatch("carry_out", 16'(carry_out), 16'(want.c));
        if (zero_out !== want.z)
          report_mismatch("zero_out", 16'(zero_out), 16'(want.z));
        if (half_out !== want.h)
          report_mismatch("half_out", 16'(half_out), 16'(want.h));
        if (overflow_out !== want.v)
          report_mismatch("overflow_out", 16'(overflow_out), 16'(want.v));
        if (negative_out !== want.n)
          report_mismatch("negative_out", 16'(negative_out), 16'(want.n));
        if (flag_mask !== want.mask)
          report_mismatch("flag_mask", 16'(flag_mask), 16'(want.mask));
      end
      result_count++;
    end
  end

  // Ends the run if it takes far longer than the slowest correct run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_with_idling();
    test_full_rate();
    test_receiver_hold();
    test_sender_pause();
    wait_for_results();
    repeat (PIPE_LATENCY * 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: byte_and_word_alu_with_flags.f
+incdir+sv
sv/bwalu_pkg.sv
sv/bwalu_front.sv
sv/byte_and_word_alu_with_flags.sv
tb/tb.sv
